### design/psb_pkg.sv
// ---------------------------------------------------------------------------
// psb_pkg
// Shared constants, codes and types for the scaled palette blitter.
// ---------------------------------------------------------------------------
package psb_pkg;

  localparam int unsigned MaxSourceDim  = 512;
  localparam int unsigned ScreenColumns = 320;
  localparam int unsigned ScreenRows    = 240;
  localparam int unsigned MapAw         = $clog2(MaxSourceDim);

  typedef enum logic [2:0] {
    ACT_PALETTE = 3'd0,
    ACT_BUILD   = 3'd1,
    ACT_START   = 3'd2,
    ACT_PIXEL   = 3'd3,
    ACT_END     = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    KIND_WRITE    = 3'd0,
    KIND_RECT     = 3'd1,
    KIND_NOCHANGE = 3'd2,
    KIND_BUILT    = 3'd3,
    KIND_REJECT   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1
  } reg_e;

  // Sequential divider request/response.
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [12:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

endpackage

### design/palette_scaled_blitter_dirty_rect.sv
// ---------------------------------------------------------------------------
// palette_scaled_blitter_dirty_rect
// Nearest-neighbor scaled palette blit into an RGB565 canvas, with the
// frame's dirty rectangle tracked and reported at frame end.
// ---------------------------------------------------------------------------
// Channel | direction | handshake            | payload
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index_i, cfg_data_i
// in      | in        | in_valid/in_ready    | action .. transparent_index
// out     | out       | out_valid/out_ready  | kind .. color
//
// Palette write, frame start, frame end: handled on acceptance. Pixel: issue
// memory reads, registered data back, check and emit, a sequence set by the
// registered map and palette memories. Build: two divides for the scale
// factors, then a divide start plus a divide per map entry over source width
// plus source height entries, then the ST_DONE and ST_WAIT states post
// the result, all sequenced by the shared serial divider. Maps and
// palette need no clearing pass: map entries carry a valid bit in the stored
// word, and entries at or above the source size of the last build are masked
// by a bound check against that size.
// A stalled result holds the block; the next item is taken once the pending result has been taken.
// ---------------------------------------------------------------------------
module palette_scaled_blitter_dirty_rect import psb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action_i,
  input  logic [11:0] src_x_i,
  input  logic [11:0] src_y_i,
  input  logic [7:0]  color_index_i,
  input  logic [15:0] palette_color_i,
  input  logic        has_transparency_i,
  input  logic [7:0]  transparent_index_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind_o,
  output logic [9:0]  pos_x_o,
  output logic [9:0]  pos_y_o,
  output logic [10:0] rect_width_o,
  output logic [10:0] rect_height_o,
  output logic [15:0] color_o
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_PXRD  = 11'b00000000010,
    ST_PXCHK = 11'b00000000100,
    ST_FIT   = 11'b00000001000,
    ST_SH    = 11'b00000010000,
    ST_CINIT = 11'b00000100000,
    ST_CDIV  = 11'b00001000000,
    ST_RINIT = 11'b00010000000,
    ST_RDIV  = 11'b00100000000,
    ST_DONE  = 11'b01000000000,
    ST_WAIT  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // Map word: {valid, 11-bit destination}; valid bit lives in the memory.
  logic [11:0] col_mem [MaxSourceDim];
  logic [11:0] row_mem [MaxSourceDim];
  logic [15:0] pal_mem [256];
  logic [11:0] col_rd_q, row_rd_q;
  logic [15:0] pal_rd_q;

  logic [12:0] src_w_q, src_h_q;
  logic        maps_ready_q;
  logic [10:0] sw_q, sh_q;
  logic [9:0]  offx_q, offy_q;
  logic [11:0] dl_q, dt_q, dr_q, db_q;   // signed, 12 bits
  logic [12:0] lim_q;                    // effective entries for the map fill
  logic [12:0] map_w_q, map_h_q;         // source size of the last build
  logic [12:0] idx_q;
  logic [10:0] prev_q;
  logic        has_t_q;
  logic [7:0]  cidx_q, tidx_q;
  logic        pix_ok_q;

  logic        out_valid_q;
  logic [2:0]  kind_q;
  logic [9:0]  px_q, py_q;
  logic [10:0] w_q, h_q;
  logic [15:0] col_q;

  div_req_t dreq;
  div_rsp_t drsp;

  psb_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
  wire   acc       = in_valid && in_ready;
  wire   out_free  = !out_valid_q || out_ready;

  // Map write port, driven by the fill sequencer.
  logic        cwe, rwe;
  logic [11:0] mwdata;
  wire  [MapAw-1:0] widx = idx_q[MapAw-1:0];
  wire  [10:0]      dval = drsp.quo[10:0];

  assign mwdata = {(idx_q == 13'd0) || (dval != prev_q), dval};
  assign cwe    = (state_q == ST_CDIV) && drsp.done;
  assign rwe    = (state_q == ST_RDIV) && drsp.done;

  // Read on the accepting edge only; hold the data through the check.
  always_ff @(posedge clk_i) begin
    if (cwe) col_mem[widx] <= mwdata;
    if (rwe) row_mem[widx] <= mwdata;
    if (acc && action_i == ACT_PALETTE && src_x_i[11:8] == 4'd0) begin
      pal_mem[src_x_i[7:0]] <= palette_color_i;
    end
    if (acc) begin
      col_rd_q <= col_mem[src_x_i[MapAw-1:0]];
      row_rd_q <= row_mem[src_y_i[MapAw-1:0]];
      pal_rd_q <= pal_mem[color_index_i];
    end
  end

  wire bad = (src_w_q == 13'd0) || (src_h_q == 13'd0) ||
             (src_w_q > 13'(MaxSourceDim)) || (src_h_q > 13'(MaxSourceDim));

  // Divider operands per step of the build.
  always_comb begin
    dreq = '0;
    case (state_q)
      ST_IDLE: begin
        dreq.start = acc && action_i == ACT_BUILD && !bad;
        dreq.num   = 32'(src_w_q) * 32'(ScreenRows);
        dreq.den   = src_h_q;
      end
      ST_FIT: begin
        dreq.start = drsp.done;
        dreq.num   = 32'((drsp.quo < 32'(ScreenColumns)) ? drsp.quo[10:0]
                         : 11'(ScreenColumns)) * 32'(src_h_q);
        dreq.den   = src_w_q;
      end
      ST_CINIT: begin
        dreq.start = 1'b1;
        dreq.num   = 32'(idx_q) * 32'(sw_q);
        dreq.den   = src_w_q;
      end
      ST_RINIT: begin
        dreq.start = 1'b1;
        dreq.num   = 32'(idx_q) * 32'(sh_q);
        dreq.den   = src_h_q;
      end
      default: dreq = '0;
    endcase
  end

  logic [10:0] fitw;
  assign fitw = (drsp.quo < 32'(ScreenColumns)) ? drsp.quo[10:0] : 11'(ScreenColumns);

  // Pixel checks on registered memory data.
  wire [11:0] dx = {1'b0, col_rd_q[10:0]};
  wire [11:0] dy = {1'b0, row_rd_q[10:0]};
  wire pix_hit = pix_ok_q && col_rd_q[11] && row_rd_q[11] &&
                 !(has_t_q && cidx_q == tidx_q);
  wire empty = ($signed(db_q) < $signed(dt_q)) || ($signed(dr_q) < $signed(dl_q));
  wire [11:0] rw = dr_q - dl_q + 12'd1;
  wire [11:0] rh = db_q - dt_q + 12'd1;

  wire set_out = (acc && (action_i == ACT_END || (action_i == ACT_BUILD && bad))) ||
                 (state_q == ST_DONE && out_free) ||
                 (state_q == ST_PXCHK && pix_hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      src_w_q      <= 13'd1;
      src_h_q      <= 13'd1;
      maps_ready_q <= 1'b0;
      sw_q         <= '0;
      sh_q         <= '0;
      offx_q       <= '0;
      offy_q       <= '0;
      dl_q         <= '0;
      dt_q         <= '0;
      dr_q         <= '1;
      db_q         <= '1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid) begin
        if (cfg_index_i == 1'(REG_SRC_W)) src_w_q <= cfg_data_i;
        else                              src_h_q <= cfg_data_i;
      end
      // Raise on a new result, drop once the beat is taken.
      if (set_out) out_valid_q <= 1'b1;
      else if (out_ready) out_valid_q <= 1'b0;
      // Frame start: collapse the rectangle.
      if (acc && action_i == ACT_START) begin
        dl_q <= {1'b0, sw_q};
        dt_q <= {1'b0, sh_q};
        dr_q <= '1;
        db_q <= '1;
      end
      if (state_q == ST_FIT && drsp.done) sw_q <= fitw;
      if (state_q == ST_SH && drsp.done) begin
        sh_q   <= drsp.quo[10:0];
        offx_q <= 10'((11'(ScreenColumns) - sw_q) >> 1);
        offy_q <= 10'((11'(ScreenRows) - drsp.quo[10:0]) >> 1);
      end
      if (state_q == ST_DONE && out_free) begin
        maps_ready_q <= 1'b1;
      end
      // Pixel: widen the rectangle.
      if (state_q == ST_PXCHK && pix_hit) begin
        if ($signed(dx) < $signed(dl_q)) dl_q <= dx;
        if ($signed(dx) > $signed(dr_q)) dr_q <= dx;
        if ($signed(dy) < $signed(dt_q)) dt_q <= dy;
        if ($signed(dy) > $signed(db_q)) db_q <= dy;
      end
    end
  end

  // Map fill counters and pixel side data.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      has_t_q  <= has_transparency_i;
      cidx_q   <= color_index_i;
      tidx_q   <= transparent_index_i;
      pix_ok_q <= maps_ready_q && ({1'b0, src_x_i} < map_w_q) &&
                  ({1'b0, src_y_i} < map_h_q);
    end
    if (state_q == ST_SH && drsp.done) begin
      idx_q   <= '0;
      lim_q   <= src_w_q;
      map_w_q <= src_w_q;
      map_h_q <= src_h_q;
    end
    if (cwe && idx_q + 13'd1 == lim_q) begin
      prev_q <= dval;
      idx_q  <= '0;
      lim_q  <= src_h_q;
    end else if (cwe || rwe) begin
      prev_q <= dval;
      idx_q  <= idx_q + 13'd1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (acc && action_i == ACT_END) begin
      kind_q <= empty ? KIND_NOCHANGE : KIND_RECT;
      px_q   <= empty ? 10'd0 : 10'(offx_q + dl_q[9:0]);
      py_q   <= empty ? 10'd0 : 10'(offy_q + dt_q[9:0]);
      w_q    <= empty ? 11'd0 : rw[10:0];
      h_q    <= empty ? 11'd0 : rh[10:0];
      col_q  <= '0;
    end else if (acc && action_i == ACT_BUILD) begin
      kind_q <= KIND_REJECT;
      px_q   <= '0;
      py_q   <= '0;
      w_q    <= '0;
      h_q    <= '0;
      col_q  <= '0;
    end else if (state_q == ST_DONE && out_free) begin
      kind_q <= KIND_BUILT;
      px_q   <= offx_q;
      py_q   <= offy_q;
      w_q    <= sw_q;
      h_q    <= sh_q;
      col_q  <= '0;
    end else if (state_q == ST_PXCHK) begin
      kind_q <= KIND_WRITE;
      px_q   <= dx[9:0];
      py_q   <= dy[9:0];
      w_q    <= '0;
      h_q    <= '0;
      col_q  <= pal_rd_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && action_i == ACT_PIXEL) state_d = ST_PXRD;
        else if (acc && action_i == ACT_BUILD && !bad) state_d = ST_FIT;
      end
      ST_PXRD:  state_d = ST_PXCHK;
      ST_PXCHK: state_d = ST_IDLE;
      ST_FIT:   if (drsp.done) state_d = ST_SH;
      ST_SH:    if (drsp.done) state_d = ST_CINIT;
      ST_CINIT: state_d = ST_CDIV;
      ST_CDIV:  if (drsp.done) state_d = (idx_q + 13'd1 == lim_q) ? ST_RINIT : ST_CINIT;
      ST_RINIT: state_d = ST_RDIV;
      ST_RDIV:  if (drsp.done) state_d = (idx_q + 13'd1 == lim_q) ? ST_DONE : ST_RINIT;
      ST_DONE:  if (out_free) state_d = ST_WAIT;
      ST_WAIT:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign out_valid     = out_valid_q;
  assign kind_o        = kind_q;
  assign pos_x_o       = px_q;
  assign pos_y_o       = py_q;
  assign rect_width_o  = w_q;
  assign rect_height_o = h_q;
  assign color_o       = col_q;

  // Hold: no new beat while a result waits.
  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_ready) else $error("accept with pending result");
  a_map_write_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cwe && rwe)) else $error("both maps written at once");
  a_pixel_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PXRD |=> state_q == ST_PXCHK) else $error("pixel sequence broken");

endmodule

### design/psb_div.sv
// ---------------------------------------------------------------------------
// psb_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module psb_div import psb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [31:0] quo_q, quo_d;
  logic [13:0] rem_q, rem_d;
  logic [12:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [13:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[12:0], quo_q[31]};
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule
